// ----- design/button_press_classifier_with_buzzer_defines.svh -----
// Assertion helpers used by the top-level design file.
`ifndef BUTTON_PRESS_CLASSIFIER_WITH_BUZZER_DEFINES_SVH
`define BUTTON_PRESS_CLASSIFIER_WITH_BUZZER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/bpc_pkg.sv -----
package bpc_pkg;

  localparam int unsigned HOLD_COUNT_BITS_DEF = 16;
  localparam int unsigned CFG_INDEX_BITS      = 3;
  localparam int unsigned CFG_DATA_BITS       = 16;

  // Keys sit on port bits 0, 1, 2 and 5.
  localparam logic [5:0] KEY_MASK    = 6'b100111;
  localparam logic [2:0] BEEP_WINDOW = 3'd5;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_SHORT_PRESS = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LONG_PRESS  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ACTIVE_LOW  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SHORT_BEEP  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LONG_BEEP   = 3'd4;

  // Register reset values
  localparam logic [15:0] SHORT_PRESS_RST = 16'd30;
  localparam logic [15:0] LONG_PRESS_RST  = 16'd1000;
  localparam logic        ACTIVE_LOW_RST  = 1'b1;
  localparam logic [8:0]  SHORT_BEEP_RST  = 9'd80;
  localparam logic [8:0]  LONG_BEEP_RST   = 9'd280;

  // Press kinds
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_SHORT = 2'd1;
  localparam logic [1:0] KIND_LONG  = 2'd2;

  typedef struct packed {
    logic [15:0] short_press_ticks;
    logic [15:0] long_press_ticks;
    logic        active_low;
    logic [8:0]  short_beep_ticks;
    logic [8:0]  long_beep_ticks;
  } cfg_t;

  typedef struct packed {
    logic       active;
    logic [8:0] elapsed;
    logic [8:0] length;
  } beep_t;

  function automatic beep_t beep_advance(beep_t b);
    beep_t r;
    r = b;
    if (b.active) begin
      if (b.elapsed < b.length) begin
        r.elapsed = b.elapsed + 9'd1;
      end else begin
        r.active  = 1'b0;
        r.elapsed = 9'd0;
      end
    end
    return r;
  endfunction

  // Start a beep when in the window and idle; the start tick advances once.
  function automatic beep_t beep_start(beep_t b, logic hit, logic [8:0] len);
    beep_t r;
    r = b;
    if (hit && !b.active) begin
      r.length  = len;
      r.active  = (len != 9'd0);
      r.elapsed = (len != 9'd0) ? 9'd1 : 9'd0;
    end
    return r;
  endfunction

endpackage

// ----- design/bpc_step.sv -----
module bpc_step #(
  parameter int unsigned HOLD_COUNT_BITS = bpc_pkg::HOLD_COUNT_BITS_DEF
) (
  input  bpc_pkg::cfg_t              cfg,
  input  logic [7:0]                 port_pins,
  input  logic [5:0]                 held_keys,
  input  logic [HOLD_COUNT_BITS-1:0] hold_count,
  input  bpc_pkg::beep_t             beep,
  output logic [5:0]                 held_keys_nxt,
  output logic [HOLD_COUNT_BITS-1:0] hold_count_nxt,
  output bpc_pkg::beep_t             beep_nxt,
  output logic [1:0]                 press_kind,
  output logic [5:0]                 press_keys
);
  import bpc_pkg::*;

  // Compare width: covers both the counter and the 16-bit thresholds plus window.
  localparam int unsigned CW = ((HOLD_COUNT_BITS > 16) ? HOLD_COUNT_BITS : 16) + 1;

  logic [5:0]                 keys;
  logic [HOLD_COUNT_BITS-1:0] cnt_inc;
  logic [CW-1:0]              cnt_ext;
  logic [CW-1:0]              hold_ext;
  logic [CW-1:0]              sth_ext;
  logic [CW-1:0]              lth_ext;
  logic                       short_hit;
  logic                       long_hit;
  beep_t                      beep_adv;
  beep_t                      beep_s;

  assign keys = (cfg.active_low ? ~port_pins[5:0] : port_pins[5:0]) & KEY_MASK;

  assign cnt_inc  = (hold_count != {HOLD_COUNT_BITS{1'b1}}) ?
                    hold_count + HOLD_COUNT_BITS'(1) : hold_count;
  assign cnt_ext  = CW'(cnt_inc);
  assign hold_ext = CW'(hold_count);
  assign sth_ext  = CW'(cfg.short_press_ticks);
  assign lth_ext  = CW'(cfg.long_press_ticks);

  assign short_hit = (cnt_ext >= sth_ext) && (cnt_ext < sth_ext + CW'(BEEP_WINDOW));
  assign long_hit  = (cnt_ext >= lth_ext) && (cnt_ext < lth_ext + CW'(BEEP_WINDOW));

  assign beep_adv = beep_advance(beep);
  assign beep_s   = beep_start(beep_adv, short_hit, cfg.short_beep_ticks);

  always_comb begin
    held_keys_nxt  = held_keys;
    hold_count_nxt = hold_count;
    beep_nxt       = beep_adv;
    press_kind     = KIND_NONE;
    press_keys     = 6'd0;
    if (keys != 6'd0 && held_keys == 6'd0) begin
      held_keys_nxt = keys;
    end else if (keys == 6'd0 && held_keys != 6'd0) begin
      // release: bounce test first, then long, then short
      if (hold_ext < sth_ext) begin
        press_kind = KIND_NONE;
      end else if (hold_ext >= lth_ext) begin
        press_kind = KIND_LONG;
        press_keys = held_keys;
      end else begin
        press_kind = KIND_SHORT;
        press_keys = held_keys;
      end
      held_keys_nxt  = 6'd0;
      hold_count_nxt = '0;
    end else if (keys != 6'd0) begin
      hold_count_nxt = cnt_inc;
      beep_nxt       = beep_start(beep_s, long_hit, cfg.long_beep_ticks);
    end
  end

endmodule

// ----- design/button_press_classifier_with_buzzer.sv -----
// Each tick passes the input register and then the result register, where its result is
// held while out_ready is low.
// Throughput: 1 tick per cycle while out_ready does not stall the result register; all press
// and beep logic sits in one stage between the input register and the result register.
// Reset (rst_n low, synchronous): pipeline empty, press and beep state cleared,
// registers back to their defaults (30, 1000, active low, 80, 280).
module button_press_classifier_with_buzzer #(
  parameter int unsigned HOLD_COUNT_BITS = bpc_pkg::HOLD_COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_port_pins,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_press_kind,
  output logic [5:0]                          out_press_keys,
  output logic                                out_buzzer,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bpc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [bpc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import bpc_pkg::*;

  `include "button_press_classifier_with_buzzer_defines.svh"

  cfg_t                       cfg_r;
  logic                       s1_valid_r;
  logic [7:0]                 s1_port_r;
  logic                       out_valid_r;
  logic [1:0]                 press_kind_r;
  logic [5:0]                 press_keys_r;
  logic                       buzzer_r;
  logic [5:0]                 held_keys_r;
  logic [HOLD_COUNT_BITS-1:0] hold_count_r;
  beep_t                      beep_r;

  logic [5:0]                 held_keys_nxt;
  logic [HOLD_COUNT_BITS-1:0] hold_count_nxt;
  beep_t                      beep_nxt;
  logic [1:0]                 press_kind_nxt;
  logic [5:0]                 press_keys_nxt;
  logic                       advance;

  // Stage 1 moves to the result register when that is empty or being drained.
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  assign out_valid      = out_valid_r;
  assign out_press_kind = press_kind_r;
  assign out_press_keys = press_keys_r;
  assign out_buzzer     = buzzer_r;

  bpc_step #(
    .HOLD_COUNT_BITS (HOLD_COUNT_BITS)
  ) u_step (
    .cfg            (cfg_r),
    .port_pins      (s1_port_r),
    .held_keys      (held_keys_r),
    .hold_count     (hold_count_r),
    .beep           (beep_r),
    .held_keys_nxt  (held_keys_nxt),
    .hold_count_nxt (hold_count_nxt),
    .beep_nxt       (beep_nxt),
    .press_kind     (press_kind_nxt),
    .press_keys     (press_keys_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_press_ticks <= SHORT_PRESS_RST;
      cfg_r.long_press_ticks  <= LONG_PRESS_RST;
      cfg_r.active_low        <= ACTIVE_LOW_RST;
      cfg_r.short_beep_ticks  <= SHORT_BEEP_RST;
      cfg_r.long_beep_ticks   <= LONG_BEEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SHORT_PRESS: cfg_r.short_press_ticks <= cfg_data[15:0];
        REG_LONG_PRESS:  cfg_r.long_press_ticks  <= cfg_data[15:0];
        REG_ACTIVE_LOW:  cfg_r.active_low        <= cfg_data[0];
        REG_SHORT_BEEP:  cfg_r.short_beep_ticks  <= cfg_data[8:0];
        REG_LONG_BEEP:   cfg_r.long_beep_ticks   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      held_keys_r  <= 6'd0;
      hold_count_r <= '0;
      beep_r       <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_valid_r && advance) begin
        held_keys_r  <= held_keys_nxt;
        hold_count_r <= hold_count_nxt;
        beep_r       <= beep_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_port_r <= in_port_pins;
    end
    if (s1_valid_r && advance) begin
      press_kind_r <= press_kind_nxt;
      press_keys_r <= press_keys_nxt;
      buzzer_r     <= beep_nxt.active;
    end
  end

  `BPC_ASSERT_IMP(a_beep_idle_clear, clk, rst_n, !beep_r.active, beep_r.elapsed == 9'd0, "beep elapsed not cleared while idle")
  `BPC_ASSERT_IMP(a_beep_in_range, clk, rst_n, beep_r.active, beep_r.elapsed <= beep_r.length, "beep elapsed beyond length")
  `BPC_ASSERT_IMP(a_idle_count_zero, clk, rst_n, held_keys_r == 6'd0, hold_count_r == '0, "hold count running with no press")
  `BPC_ASSERT_IMP(a_press_has_keys, clk, rst_n, out_valid_r && (press_kind_r != KIND_NONE), press_keys_r != 6'd0, "press reported without keys")
  `BPC_ASSERT_NEXT(a_stall_holds_result, clk, rst_n, out_valid_r && !out_ready, out_valid_r && $stable(press_kind_r) && $stable(buzzer_r) && $stable(beep_r), "stalled result or beep state changed")

endmodule

// ----- tb/sv/tb_button_press_classifier_with_buzzer.sv -----
`timescale 1ns / 100ps

module tb_button_press_classifier_with_buzzer;
  import bpc_pkg::*;

  localparam int unsigned HC_BITS = HOLD_COUNT_BITS_DEF;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned RAND_PHASES = 6;
  localparam int unsigned PHASE_TICKS = 55;
  localparam logic [7:0] NON_KEY_BITS = ~{2'b00, KEY_MASK};
  localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_UNUSED = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LAST_UNUSED = 3'd7;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] keys;
    logic       buzz;
  } press_result_t;

  localparam press_result_t NO_PRESS = '{KIND_NONE, 6'h00, 1'b0};

  typedef enum logic {ROW_TICK, ROW_REG} row_op_t;

  typedef struct packed {
    row_op_t                   op;
    logic [7:0]                pins;
    int unsigned               reps;
    logic [CFG_INDEX_BITS-1:0] idx;
    logic [CFG_DATA_BITS-1:0]  data;
    logic                      typed;
    press_result_t             want;
  } stim_row_t;

  localparam int NUM_ROWS = 37;
  localparam stim_row_t DIR_ROWS [NUM_ROWS] = '{
    // reset settings: active low, 30 / 1000, beeps 80 / 280
    '{ROW_TICK, 8'hFF, 1, '0, '0, 1'b1, NO_PRESS},
    '{ROW_TICK, 8'hFE, 1, '0, '0, 1'b1, NO_PRESS},
    '{ROW_TICK, 8'hFE, 9, '0, '0, 1'b0, NO_PRESS},
    '{ROW_TICK, 8'hFF, 1, '0, '0, 1'b1, NO_PRESS},      // bounce
    '{ROW_TICK, 8'hDA, 1, '0, '0, 1'b0, NO_PRESS},
    '{ROW_TICK, 8'h00, 40, '0, '0, 1'b0, NO_PRESS},     // keys change while held
    '{ROW_TICK, 8'hFF, 1, '0, '0, 1'b0, NO_PRESS},
    '{ROW_TICK, 8'hFF, 20, '0, '0, 1'b0, NO_PRESS},
    // long press with a shorter long threshold and long beep
    '{ROW_REG, 8'h00, 0, REG_LONG_PRESS, 16'd60, 1'b0, NO_PRESS},
    '{ROW_REG, 8'h00, 0, REG_LONG_BEEP, 16'd20, 1'b0, NO_PRESS},
    '{ROW_TICK, 8'h00, 65, '0, '0, 1'b0, NO_PRESS},
    '{ROW_TICK, 8'hFF, 1, '0, '0, 1'b0, NO_PRESS},
    '{ROW_TICK, 8'hFF, 30, '0, '0, 1'b0, NO_PRESS},
    // active high, zero thresholds
    '{ROW_REG, 8'h00, 0, REG_ACTIVE_LOW, 16'hFFFE, 1'b0, NO_PRESS},
    '{ROW_REG, 8'h00, 0, REG_SHORT_PRESS, 16'h0000, 1'b0, NO_PRESS},
    '{ROW_REG, 8'h00, 0, REG_LONG_PRESS, 16'h0000, 1'b0, NO_PRESS},
    '{ROW_TICK, 8'h01, 1, '0, '0, 1'b1, NO_PRESS},
    '{ROW_TICK, 8'h00, 1, '0, '0, 1'b1, '{KIND_LONG, 6'h01, 1'b0}},
    '{ROW_TICK, 8'hD8, 1, '0, '0, 1'b1, NO_PRESS},      // only non-key bits
    // short above long, zero-length short beep, masked long beep
    '{ROW_REG, 8'h00, 0, REG_SHORT_PRESS, 16'd10, 1'b0, NO_PRESS},
    '{ROW_REG, 8'h00, 0, REG_LONG_PRESS, 16'd5, 1'b0, NO_PRESS},
    '{ROW_REG, 8'h00, 0, REG_SHORT_BEEP, 16'h0000, 1'b0, NO_PRESS},
    '{ROW_REG, 8'h00, 0, REG_LONG_BEEP, 16'hFFFF, 1'b0, NO_PRESS},
    '{ROW_REG, 8'h00, 0, REG_FIRST_UNUSED, 16'hA5A5, 1'b0, NO_PRESS},
    '{ROW_REG, 8'h00, 0, REG_LAST_UNUSED, 16'h5A5A, 1'b0, NO_PRESS},
    '{ROW_TICK, 8'h20, 8, '0, '0, 1'b0, NO_PRESS},
    '{ROW_TICK, 8'h00, 1, '0, '0, 1'b0, NO_PRESS},
    '{ROW_TICK, 8'h24, 12, '0, '0, 1'b0, NO_PRESS},
    '{ROW_TICK, 8'h00, 1, '0, '0, 1'b0, NO_PRESS},
    '{ROW_TICK, 8'h00, 20, '0, '0, 1'b0, NO_PRESS},
    // thresholds at the top of the range
    '{ROW_REG, 8'h00, 0, REG_SHORT_PRESS, 16'd65533, 1'b0, NO_PRESS},
    '{ROW_REG, 8'h00, 0, REG_LONG_PRESS, 16'hFFFF, 1'b0, NO_PRESS},
    '{ROW_REG, 8'h00, 0, REG_SHORT_BEEP, 16'd3, 1'b0, NO_PRESS},
    '{ROW_REG, 8'h00, 0, REG_LONG_BEEP, 16'd0, 1'b0, NO_PRESS},
    '{ROW_TICK, 8'h07, 10, '0, '0, 1'b0, NO_PRESS},
    '{ROW_TICK, 8'h00, 1, '0, '0, 1'b0, NO_PRESS},
    '{ROW_TICK, 8'h00, 5, '0, '0, 1'b0, NO_PRESS}
  };

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_port_pins = 8'h00;
  logic out_valid;
  logic out_ready = 1'b1;
  logic [1:0] out_press_kind;
  logic [5:0] out_press_keys;
  logic out_buzzer;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  button_press_classifier_with_buzzer dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_port_pins  (in_port_pins),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_press_kind(out_press_kind),
    .out_press_keys(out_press_keys),
    .out_buzzer    (out_buzzer),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // predictor state
  cfg_t cur_cfg = '{SHORT_PRESS_RST, LONG_PRESS_RST, ACTIVE_LOW_RST, SHORT_BEEP_RST,
                    LONG_BEEP_RST};
  logic [5:0] keys_latched = '0;
  logic [HC_BITS-1:0] hold_ticks = '0;
  logic beep_on = 1'b0;
  logic [8:0] beep_cnt = '0;
  logic [8:0] beep_len = '0;

  press_result_t press_results_due[$];
  press_result_t want_r;
  int unsigned idle_pct = 20;
  int unsigned stall_left = 0;
  int unsigned fails = 0;
  int unsigned ticks_sent = 0;
  int unsigned regs_written = 0;
  int unsigned shorts_seen = 0;
  int unsigned longs_seen = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic void tone_step();
    if (beep_cnt < beep_len) begin
      beep_cnt = beep_cnt + 9'd1;
    end else begin
      beep_on = 1'b0;
      beep_cnt = '0;
    end
  endfunction

  // window is threshold .. threshold+4, formed wider than 16 bits
  function automatic void tone_try(logic [15:0] th, logic [8:0] len);
    int unsigned lo;
    int unsigned cnt;
    lo = 32'(th);
    cnt = 32'(hold_ticks);
    if (cnt >= lo && cnt < lo + BEEP_WINDOW && !beep_on) begin
      beep_len = len;
      beep_on = 1'b1;
      tone_step();
    end
  endfunction

  function automatic press_result_t classify_tick(logic [7:0] pins);
    logic [7:0] lv;
    logic [5:0] k;
    press_result_t r;
    r = NO_PRESS;
    lv = cur_cfg.active_low ? ~pins : pins;
    k = lv[5:0] & KEY_MASK;
    if (beep_on) tone_step();
    if (keys_latched == '0) begin
      keys_latched = k;
    end else if (k == '0) begin
      // bounce test first, then long, then short
      if (hold_ticks < cur_cfg.short_press_ticks) begin
        r.kind = KIND_NONE;
      end else if (hold_ticks >= cur_cfg.long_press_ticks) begin
        r.kind = KIND_LONG;
        r.keys = keys_latched;
      end else begin
        r.kind = KIND_SHORT;
        r.keys = keys_latched;
      end
      keys_latched = '0;
      hold_ticks = '0;
    end else begin
      if (hold_ticks != '1) hold_ticks = hold_ticks + 1'b1;
      tone_try(cur_cfg.short_press_ticks, cur_cfg.short_beep_ticks);
      tone_try(cur_cfg.long_press_ticks, cur_cfg.long_beep_ticks);
    end
    r.buzz = beep_on;
    return r;
  endfunction

  function automatic void apply_reg(logic [CFG_INDEX_BITS-1:0] idx,
                                    logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_SHORT_PRESS: cur_cfg.short_press_ticks = data;
      REG_LONG_PRESS:  cur_cfg.long_press_ticks = data;
      REG_ACTIVE_LOW:  cur_cfg.active_low = data[0];
      REG_SHORT_BEEP:  cur_cfg.short_beep_ticks = data[8:0];
      REG_LONG_BEEP:   cur_cfg.long_beep_ticks = data[8:0];
      default: ;
    endcase
  endfunction

  function automatic logic [5:0] rand_keys();
    logic [5:0] k;
    do k = 6'($urandom) & KEY_MASK; while (k == '0);
    return k;
  endfunction

  // port levels for a key pattern, with junk on the non-key bits
  function automatic logic [7:0] level_pins(logic [5:0] k);
    logic [7:0] lv;
    lv = (8'($urandom) & NON_KEY_BITS) | {2'b00, k & KEY_MASK};
    return cur_cfg.active_low ? ~lv : lv;
  endfunction

  task automatic send_tick(input logic [7:0] pins, input logic typed, input press_result_t want);
    int unsigned gap;
    press_result_t got;
    gap = 0;
    if ($urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 6);
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_port_pins <= pins;
    do @(posedge clk); while (!in_ready);
    got = classify_tick(pins);
    press_results_due.push_back(typed ? want : got);
    ticks_sent++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    regs_written++;
  endtask

  task automatic close_cfg();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (press_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // optional idle gap, press, hold near a threshold or for a random length with key changes, release
  task automatic send_press();
    int th;
    int len;
    logic [5:0] k;
    repeat ($urandom_range(0, 3)) send_tick(level_pins(6'h00), 1'b0, NO_PRESS);
    case ($urandom_range(0, 2))
      0: th = int'(cur_cfg.short_press_ticks);
      1: th = int'(cur_cfg.long_press_ticks);
      default: th = int'($urandom_range(0, 35));
    endcase
    len = th + int'($urandom_range(0, 7)) - 2;
    if (len < 0) len = 0;
    k = rand_keys();
    send_tick(level_pins(k), 1'b0, NO_PRESS);
    repeat (len) begin
      if ($urandom_range(0, 7) == 0) k = rand_keys();
      send_tick(level_pins(k), 1'b0, NO_PRESS);
    end
    send_tick(level_pins(6'h00), 1'b0, NO_PRESS);
  endtask

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (rst_n && $urandom_range(0, 99) < idle_pct) begin
      stall_left <= $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (press_results_due.size() == 0) begin
        $error("result transfer with no expected result pending");
        fails++;
      end else begin
        want_r = press_results_due.pop_front();
        if (out_press_kind != want_r.kind) begin
          $error("press_kind: expected %0d, actual %0d", want_r.kind, out_press_kind);
          fails++;
        end
        if (out_press_keys != want_r.keys) begin
          $error("press_keys: expected 0x%0h, actual 0x%0h", want_r.keys, out_press_keys);
          fails++;
        end
        if (out_buzzer != want_r.buzz) begin
          $error("buzzer: expected %0d, actual %0d", want_r.buzz, out_buzzer);
          fails++;
        end
        if (want_r.kind == KIND_SHORT) shorts_seen++;
        if (want_r.kind == KIND_LONG) longs_seen++;
      end
    end
  end

  initial begin
    stim_row_t row;
    logic cfg_open;
    int unsigned start;
    cfg_open = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_ROWS; i++) begin
      row = DIR_ROWS[i];
      if (row.op == ROW_REG) begin
        if (!cfg_open) begin
          wait_idle();
          cfg_open = 1'b1;
        end
        write_reg(row.idx, row.data);
      end else begin
        if (cfg_open) begin
          close_cfg();
          cfg_open = 1'b0;
        end
        for (int unsigned r = 0; r < row.reps; r++) begin
          send_tick(row.pins, row.typed && r == row.reps - 1, row.want);
        end
      end
    end

    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      write_reg(REG_ACTIVE_LOW, 16'($urandom));
      write_reg(REG_SHORT_PRESS, 16'($urandom_range(0, 12)));
      write_reg(REG_LONG_PRESS, 16'($urandom_range(0, 30)));
      write_reg(REG_SHORT_BEEP, {7'($urandom), 9'($urandom_range(0, 20))});
      write_reg(REG_LONG_BEEP, {7'($urandom), 9'($urandom_range(0, 40))});
      write_reg(3'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)), 16'($urandom));
      close_cfg();
      // no idling at all in the final phase
      if (ph == RAND_PHASES - 1) idle_pct = 0;
      else idle_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 15 : 40);
      start = ticks_sent;
      while (ticks_sent - start < PHASE_TICKS) begin
        if ($urandom_range(0, 9) == 0) send_tick(8'($urandom), 1'b0, NO_PRESS);
        else send_press();
      end
    end

    wait_idle();
    $display("Sent %0d ticks and %0d register writes over %0d random setting phases;",
             ticks_sent, regs_written, RAND_PHASES);
    $display("checked %0d short and %0d long presses with beeps and bounces.",
             shorts_seen, longs_seen);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- button_press_classifier_with_buzzer.f -----
+incdir+design
design/bpc_pkg.sv
design/bpc_step.sv
design/button_press_classifier_with_buzzer.sv
tb/sv/tb_button_press_classifier_with_buzzer.sv
